/* rtl/core/ocs_pkg.sv */
// Shared types, constants and helpers for the odd column sum sorter.
// No dependencies; imported by every module of the block but ocs_ram.
`timescale 1ns / 1ps

package ocs_pkg;

    localparam int ELEM_W   = 16;   // element width
    localparam int SUM_W    = 22;   // column sum width
    localparam int POS_W    = 6;    // row / column position width
    localparam int CNT_W    = 7;    // configured count width
    localparam int SLOTS    = 32;   // odd column slots
    localparam int SLOT_W   = 5;    // slot index width
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ADDR_W   = 3;    // APB address width
    localparam int DATA_W   = 32;   // APB data width

    localparam logic [CNT_W-1:0] ROWS_RST = CNT_W'(4);
    localparam logic [CNT_W-1:0] COLS_RST = CNT_W'(4);

    // register index, taken from paddr[2]
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] row_count;
        logic [CNT_W-1:0] column_count;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SETTLE,
        ST_KEY,
        ST_SCAN,
        ST_RANK,
        ST_OUT_ORD,
        ST_OUT_SUM,
        ST_EMIT
    } state_t;

    function automatic logic [CNT_W-1:0] rows_eff(input logic [CNT_W-1:0] r);
        logic [CNT_W-1:0] v;
        priority if (r == '0)
            v = CNT_W'(1);
        else if (r > CNT_W'(MAX_ROWS))
            v = CNT_W'(MAX_ROWS);
        else
            v = r;
        return v;
    endfunction

    function automatic logic [CNT_W-1:0] cols_eff(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] v;
        priority if (c < CNT_W'(2))
            v = CNT_W'(2);
        else if (c > CNT_W'(MAX_COLS))
            v = CNT_W'(MAX_COLS);
        else
            v = c;
        return v;
    endfunction

endpackage

/* rtl/core/odd_column_sum_sort_order_unit.sv */
// Loading: one element per cycle; start is taken whenever busy is low.
// After the last element: a settle state, then ranking (one pass over the sum RAM
// per odd column, of which there are column_count/2), then the results in rank
// order, each strobed for one cycle; busy drops after the last.
// Reset (rst_n low, async): counts 4x4, positions cleared, column sums read as zero.
// Top level of the odd column sum sorter; depends on ocs_pkg, ocs_regs, ocs_ctrl.
`timescale 1ns / 1ps

module odd_column_sum_sort_order_unit
    import ocs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [ELEM_W-1:0] element,
    output logic                     result_strobe,
    output logic [POS_W-1:0]         destination,
    output logic [POS_W-1:0]         source_column,
    output logic signed [SUM_W-1:0]  column_sum,
    output logic                     last
);

    cfg_t cfg;

    ocs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ocs_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .start         (start),
        .busy          (busy),
        .element       (element),
        .result_strobe (result_strobe),
        .destination   (destination),
        .source_column (source_column),
        .column_sum    (column_sum),
        .last          (last)
    );

endmodule

/* rtl/core/ocs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ocs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/ocs_regs.sv */
// APB configuration registers: row_count and column_count.
// Depends on ocs_pkg.
`timescale 1ns / 1ps

module ocs_regs
    import ocs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [CNT_W-1:0] rows_reg, rows_next;
    logic [CNT_W-1:0] cols_reg, cols_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // low address bits act as byte lanes and are ignored
    always_comb
    begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        prdata    = '0;
        unique case (paddr[ADDR_W-1])
            REG_ROWS:
            begin
                prdata = DATA_W'(rows_reg);
                if (wr_en)
                begin
                    rows_next = pwdata[CNT_W-1:0];
                end
            end
            REG_COLS:
            begin
                prdata = DATA_W'(cols_reg);
                if (wr_en)
                begin
                    cols_next = pwdata[CNT_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= ROWS_RST;
            cols_reg <= COLS_RST;
        end
        else
        begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
        end
    end

    assign cfg.row_count    = rows_reg;
    assign cfg.column_count = cols_reg;

endmodule

/* rtl/core/ocs_ctrl.sv */
// Accumulate, rank and emit engine around the sum and order RAMs.
// Depends on ocs_pkg and ocs_ram.
`timescale 1ns / 1ps

module ocs_ctrl
    import ocs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [ELEM_W-1:0] element,
    output logic                     result_strobe,
    output logic [POS_W-1:0]         destination,
    output logic [POS_W-1:0]         source_column,
    output logic signed [SUM_W-1:0]  column_sum,
    output logic                     last
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] cols;
    logic [SLOT_W:0]  n_slots;

    logic [POS_W-1:0] row_pos_reg, row_pos_next;
    logic [POS_W-1:0] col_pos_reg, col_pos_next;

    logic                     acc_vld_reg, acc_vld_next;
    logic [SLOT_W-1:0]        acc_slot_reg;
    logic signed [ELEM_W-1:0] acc_elem_reg;

    logic [SLOTS-1:0] valid_reg, valid_next;
    logic             rd_valid_reg;

    logic [SLOT_W-1:0]       i_reg, i_next;
    logic [SLOT_W:0]         j_reg, j_next;
    logic [SLOT_W-1:0]       cnt_reg, cnt_next;
    logic signed [SUM_W-1:0] key_reg, key_next;
    logic                    cmp_vld_reg, cmp_vld_next;
    logic [SLOT_W-1:0]       k_reg, k_next;
    logic [SLOT_W-1:0]       src_reg, src_next;

    logic                    strobe_reg, strobe_next;
    logic                    last_reg, last_next;
    logic [POS_W-1:0]        dest_reg;
    logic [POS_W-1:0]        srccol_reg;
    logic signed [SUM_W-1:0] sum_out_reg;

    logic [SLOT_W-1:0]       sum_raddr;
    logic [SUM_W-1:0]        sum_rdata;
    logic signed [SUM_W-1:0] rd_val;
    logic signed [SUM_W-1:0] acc_sum;
    logic [SLOT_W-1:0]       ord_rdata;
    logic                    ord_we;
    logic                    accept;
    logic                    emit;
    logic [SLOT_W:0]         cmp_idx;
    logic                    ranks_above;

    assign rows    = rows_eff(cfg.row_count);
    assign cols    = cols_eff(cfg.column_count);
    assign n_slots = cols[CNT_W-1:1];

    assign busy   = (state_reg != ST_LOAD) || strobe_reg;
    assign accept = start && !busy;

    // slots never written since the last run read as zero
    assign rd_val  = rd_valid_reg ? $signed(sum_rdata) : '0;
    assign acc_sum = rd_val + {{(SUM_W-ELEM_W){acc_elem_reg[ELEM_W-1]}}, acc_elem_reg};

    // stable descending: larger sum, or equal sum from a lower slot, ranks ahead
    assign cmp_idx     = j_reg - (SLOT_W+1)'(1);
    assign ranks_above = (rd_val > key_reg) ||
                         ((rd_val == key_reg) && (cmp_idx < {1'b0, i_reg}));

    assign ord_we = (state_reg == ST_RANK);

    always_comb
    begin
        unique case (state_reg)
            ST_LOAD:    sum_raddr = col_pos_reg[SLOT_W:1];
            ST_KEY:     sum_raddr = i_reg;
            ST_SCAN:    sum_raddr = j_reg[SLOT_W-1:0];
            ST_OUT_SUM: sum_raddr = ord_rdata;
            default:    sum_raddr = '0;
        endcase
    end

    ocs_ram #(
        .WIDTH (SUM_W),
        .DEPTH (SLOTS)
    ) u_sum_ram (
        .clk   (clk),
        .we    (acc_vld_reg),
        .waddr (acc_slot_reg),
        .wdata (acc_sum),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    ocs_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_ord_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (cnt_reg),
        .wdata (i_reg),
        .raddr (k_reg),
        .rdata (ord_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        acc_vld_next = 1'b0;
        valid_next   = valid_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        cnt_next     = cnt_reg;
        key_next     = key_reg;
        cmp_vld_next = cmp_vld_reg;
        k_next       = k_reg;
        src_next     = src_reg;
        emit         = 1'b0;
        last_next    = 1'b0;

        if (acc_vld_reg)
        begin
            valid_next[acc_slot_reg] = 1'b1;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    acc_vld_next = col_pos_reg[0];
                    if ({1'b0, col_pos_reg} + CNT_W'(1) < cols)
                    begin
                        col_pos_next = col_pos_reg + POS_W'(1);
                    end
                    else
                    begin
                        col_pos_next = '0;
                        if ({1'b0, row_pos_reg} + CNT_W'(1) < rows)
                        begin
                            row_pos_next = row_pos_reg + POS_W'(1);
                        end
                        else
                        begin
                            row_pos_next = '0;
                            state_next   = ST_SETTLE;
                        end
                    end
                end
            end
            ST_SETTLE:
            begin
                // lets the final accumulate land before the sort reads
                i_next     = '0;
                state_next = ST_KEY;
            end
            ST_KEY:
            begin
                j_next       = '0;
                cnt_next     = '0;
                cmp_vld_next = 1'b0;
                state_next   = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (!cmp_vld_reg)
                begin
                    key_next     = rd_val;
                    cmp_vld_next = 1'b1;
                end
                else if (ranks_above)
                begin
                    cnt_next = cnt_reg + SLOT_W'(1);
                end
                if (j_reg != n_slots)
                begin
                    j_next = j_reg + (SLOT_W+1)'(1);
                end
                else
                begin
                    state_next = ST_RANK;
                end
            end
            ST_RANK:
            begin
                if ({1'b0, i_reg} + (SLOT_W+1)'(1) == n_slots)
                begin
                    k_next     = '0;
                    state_next = ST_OUT_ORD;
                end
                else
                begin
                    i_next     = i_reg + SLOT_W'(1);
                    state_next = ST_KEY;
                end
            end
            ST_OUT_ORD:
            begin
                state_next = ST_OUT_SUM;
            end
            ST_OUT_SUM:
            begin
                src_next   = ord_rdata;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                emit = 1'b1;
                if ({1'b0, k_reg} + (SLOT_W+1)'(1) == n_slots)
                begin
                    last_next  = 1'b1;
                    valid_next = '0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    k_next     = k_reg + SLOT_W'(1);
                    state_next = ST_OUT_ORD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign strobe_next = emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            row_pos_reg  <= '0;
            col_pos_reg  <= '0;
            acc_vld_reg  <= 1'b0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
            cnt_reg      <= '0;
            cmp_vld_reg  <= 1'b0;
            k_reg        <= '0;
            strobe_reg   <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_pos_reg  <= row_pos_next;
            col_pos_reg  <= col_pos_next;
            acc_vld_reg  <= acc_vld_next;
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[sum_raddr];
            i_reg        <= i_next;
            j_reg        <= j_next;
            cnt_reg      <= cnt_next;
            cmp_vld_reg  <= cmp_vld_next;
            k_reg        <= k_next;
            strobe_reg   <= strobe_next;
            last_reg     <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            acc_slot_reg <= col_pos_reg[SLOT_W:1];
            acc_elem_reg <= element;
        end
        key_reg <= key_next;
        src_reg <= src_next;
        if (emit)
        begin
            dest_reg    <= {k_reg, 1'b1};
            srccol_reg  <= {src_reg, 1'b1};
            sum_out_reg <= rd_val;
        end
    end

    assign result_strobe = strobe_reg;
    assign last          = last_reg;
    assign destination   = dest_reg;
    assign source_column = srccol_reg;
    assign column_sum    = sum_out_reg;

endmodule

/* rtl/core/ocs_checker.sv */
// Port-level checks on the result sequence of the odd column sum sorter.
// Depends on ocs_pkg; bound to odd_column_sum_sort_order_unit.
`timescale 1ns / 1ps

module ocs_checker
    import ocs_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             result_strobe,
    input logic [POS_W-1:0] destination,
    input logic [POS_W-1:0] source_column,
    input logic             last
);

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> busy)
        else $error("result strobed while not busy");

    a_odd_cols: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (destination[0] && source_column[0]))
        else $error("result names an even column");

    a_last_strobed: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> result_strobe)
        else $error("last without a result");

    a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |=> !result_strobe)
        else $error("results back to back");

    a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !last) |=> (busy && !(start && !busy)))
        else $error("input taken before the final result");

endmodule

bind odd_column_sum_sort_order_unit ocs_checker u_ocs_checker (.*);
